### rtl/core/wcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wcd_pkg
// Shared constants, register indexes, status codes and the byte-wise CRC-8
// update for the word CRC-8 deframer.
// ----------------------------------------------------------------------------
package wcd_pkg;

  // default bound on the payload length of one read
  localparam int unsigned MAX_DATA_LENGTH = 256;

  // configuration port widths
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_LEN = 2'd2;

  // register reset values
  localparam logic [7:0] CRC_POLY_RESET = 8'h31;
  localparam logic [7:0] CRC_INIT_RESET = 8'hFF;

  // field widths
  localparam int unsigned LEN_W    = 9;
  localparam int unsigned STATUS_W = 2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CRC_ERR = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LEN_ERR = 2'd2;

  // group positions
  localparam logic [1:0] POS_HIGH = 2'd0;
  localparam logic [1:0] POS_LOW  = 2'd1;
  localparam logic [1:0] POS_CRC  = 2'd2;

  // msb-first crc-8 update over one byte, eight shift steps
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/core/word_crc8_deframer_top.sv
`default_nettype none
// Each byte is held in the input register until the result register can take its result.
// Throughput: one byte per cycle; the input register and the result register
// each hold one item, so input stall only rises while both are full and the
// output is stalled.
// Reset: control state cleared, registers back to polynomial 0x31, initial
// value 0xFF, length 0; the deframer idles until a first byte arrives.
// ----------------------------------------------------------------------------
// word_crc8_deframer_top
// Checks byte groups of two data bytes and one CRC-8 byte, emits the 16-bit
// word for each good group, or a CRC / length error that ends the read.
// ----------------------------------------------------------------------------
module word_crc8_deframer_top #(
  parameter int unsigned MaxDataLength = wcd_pkg::MAX_DATA_LENGTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [wcd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [wcd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // byte input channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [7:0]                     rx_byte_i,
  input  wire logic                           first_byte_i,
  // result channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [15:0]                         word_value_o,
  output logic [wcd_pkg::STATUS_W-1:0]        result_status_o,
  output logic                                last_word_o
);

  // largest usable length and word count
  localparam int unsigned LenMax   = (1 << wcd_pkg::LEN_W) - 1;
  localparam int unsigned LenBound = (MaxDataLength < LenMax) ? MaxDataLength : LenMax;
  localparam int unsigned WordsMax = LenBound / 2;
  localparam int unsigned CntW     = (WordsMax < 2) ? 1 : $clog2(WordsMax + 1);

  // configuration registers
  logic [7:0]                crc_poly_q;
  logic [7:0]                crc_init_q;
  logic [wcd_pkg::LEN_W-1:0] data_len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_poly_q <= wcd_pkg::CRC_POLY_RESET;
      crc_init_q <= wcd_pkg::CRC_INIT_RESET;
      data_len_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        wcd_pkg::REG_CRC_POLY: crc_poly_q <= cfg_data_i[7:0];
        wcd_pkg::REG_CRC_INIT: crc_init_q <= cfg_data_i[7:0];
        wcd_pkg::REG_DATA_LEN: data_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_first_q;
  logic       out_valid_q;
  logic       out_free;
  logic       advance;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_byte_q  <= rx_byte_i;
      s1_first_q <= first_byte_i;
    end
  end

  // deframing state
  logic [7:0]      crc_acc_q, crc_acc_d;
  logic [1:0]      pos_q, pos_d;
  logic [7:0]      high_q, high_d;
  logic [7:0]      low_q, low_d;
  logic [CntW-1:0] wcnt_q, wcnt_d;
  logic            discard_q, discard_d;

  // result computed this cycle
  logic                         res_valid;
  logic [15:0]                  res_word;
  logic [wcd_pkg::STATUS_W-1:0] res_status;
  logic                         res_last;

  // effective length and expected words
  logic [wcd_pkg::LEN_W-1:0] len_eff;
  logic [CntW-1:0]           words;
  logic [1:0]                pos_eff;
  logic [CntW-1:0]           wcnt_eff;
  logic [CntW-1:0]           wcnt_inc;
  logic                      discard_eff;
  logic [7:0]                crc_in;
  logic [7:0]                crc_new;

  assign len_eff  = (32'(data_len_q) > 32'(LenBound)) ? wcd_pkg::LEN_W'(LenBound)
                                                      : data_len_q;
  assign words    = CntW'(len_eff >> 1);
  assign pos_eff  = s1_first_q ? wcd_pkg::POS_HIGH : pos_q;
  assign wcnt_eff = s1_first_q ? '0 : wcnt_q;
  assign wcnt_inc = wcnt_eff + CntW'(1);
  assign discard_eff = s1_first_q ? 1'b0 : discard_q;
  assign crc_in   = (pos_eff == wcd_pkg::POS_HIGH) ? crc_init_q : crc_acc_q;
  assign crc_new  = wcd_pkg::crc8_feed(crc_in, s1_byte_q, crc_poly_q);

  // one byte of the group
  always_comb begin
    crc_acc_d  = crc_acc_q;
    pos_d      = pos_q;
    high_d     = high_q;
    low_d      = low_q;
    wcnt_d     = wcnt_q;
    discard_d  = discard_q;
    res_valid  = 1'b0;
    res_word   = '0;
    res_status = wcd_pkg::STATUS_OK;
    res_last   = 1'b0;
    if (advance) begin
      pos_d     = pos_eff;
      wcnt_d    = wcnt_eff;
      discard_d = discard_eff;
      priority if (s1_first_q && data_len_q[0]) begin
        // odd length, drop the read
        discard_d  = 1'b1;
        res_valid  = 1'b1;
        res_status = wcd_pkg::STATUS_LEN_ERR;
        res_last   = 1'b1;
      end else if (discard_eff) begin
        // ignored byte
      end else if (wcnt_eff >= words) begin
        discard_d = 1'b1;
      end else if (pos_eff == wcd_pkg::POS_HIGH) begin
        crc_acc_d = crc_new;
        high_d    = s1_byte_q;
        pos_d     = wcd_pkg::POS_LOW;
      end else if (pos_eff == wcd_pkg::POS_LOW) begin
        crc_acc_d = crc_new;
        low_d     = s1_byte_q;
        pos_d     = wcd_pkg::POS_CRC;
      end else if (crc_acc_q != s1_byte_q) begin
        // crc byte does not match
        pos_d      = wcd_pkg::POS_HIGH;
        crc_acc_d  = crc_init_q;
        discard_d  = 1'b1;
        res_valid  = 1'b1;
        res_status = wcd_pkg::STATUS_CRC_ERR;
        res_last   = 1'b1;
      end else begin
        // good word
        pos_d     = wcd_pkg::POS_HIGH;
        crc_acc_d = crc_init_q;
        wcnt_d    = wcnt_inc;
        res_valid = 1'b1;
        res_word  = {high_q, low_q};
        res_last  = (wcnt_inc >= words);
        discard_d = res_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_acc_q <= wcd_pkg::CRC_INIT_RESET;
      pos_q     <= wcd_pkg::POS_HIGH;
      high_q    <= '0;
      low_q     <= '0;
      wcnt_q    <= '0;
      discard_q <= 1'b1;
    end else begin
      crc_acc_q <= crc_acc_d;
      pos_q     <= pos_d;
      high_q    <= high_d;
      low_q     <= low_d;
      wcnt_q    <= wcnt_d;
      discard_q <= discard_d;
    end
  end

  // result register
  logic [15:0]                  word_q;
  logic [wcd_pkg::STATUS_W-1:0] status_q;
  logic                         last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      word_q   <= res_word;
      status_q <= res_status;
      last_q   <= res_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign word_value_o    = word_q;
  assign result_status_o = status_q;
  assign last_word_o     = last_q;

  // checks
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_status_o != wcd_pkg::STATUS_OK) |-> last_word_o)
    else $error("error result without last flag");

  a_err_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_status_o != wcd_pkg::STATUS_OK) |-> (word_value_o == 16'h0000))
    else $error("error result carries a word");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

  a_last_sets_discard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_last |=> discard_q)
    else $error("final result did not close the read");

endmodule
`default_nettype wire
